// File: rtl/dmnf_pkg.sv
// Package: shared types, widths and constants of the depth mask neighbour fill unit.
package dmnf_pkg;

   // field widths
   localparam int DEPTH_W    = 16;
   localparam int FW_W       = 11;   // frame_width register
   localparam int FH_W       = 12;   // frame_height register
   localparam int CSR_DATA_W = 12;
   localparam int ROW_W      = 13;   // input row counter, reaches height + 1
   localparam int COL_X_W    = 13;   // column arithmetic, holds width + 2
   localparam int ROW_X_W    = 14;   // row arithmetic, holds row + 2

   // defaults
   localparam int MAX_WIDTH_DEF = 1024;
   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

   // result queue
   localparam int FIFO_DEPTH = 3;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // register indexes
   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // one pixel: valid mark and depth
   typedef struct packed {
      logic               valid;
      logic [DEPTH_W-1:0] depth;
   } pix_type;

   // one window column, rows from top (oldest) to bottom (newest)
   typedef struct packed {
      pix_type top;
      pix_type mid;
      pix_type bot;
   } col_type;

   // one line store entry: the two rows above the input
   typedef struct packed {
      pix_type older;
      pix_type newer;
   } pair_type;

   // one result item
   typedef struct packed {
      logic               mask_out;
      logic [DEPTH_W-1:0] depth_out;
      logic               frame_end;
   } rsp_type;

   // interior flags of the 3x3 neighbourhood
   typedef struct packed {
      logic top;
      logic mid;
      logic bot;
   } row_ok_type;

   typedef struct packed {
      logic left;
      logic centre;
      logic right;
   } col_ok_type;

endpackage

// File: rtl/dmnf_channels.sv
// Interfaces: pixel request, result and register write channels.
interface dmnf_req_if
   import dmnf_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               mask_in;
   logic [DEPTH_W-1:0] depth_in;
   logic               flush;

   modport source (output valid, mask_in, depth_in, flush, input ready);
   modport sink   (input valid, mask_in, depth_in, flush, output ready);
endinterface

interface dmnf_rsp_if
   import dmnf_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               mask_out;
   logic [DEPTH_W-1:0] depth_out;
   logic               frame_end;

   modport source (output valid, mask_out, depth_out, frame_end, input ready);
   modport sink   (input valid, mask_out, depth_out, frame_end, output ready);
endinterface

interface dmnf_csr_if
   import dmnf_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/dmnf_ram.sv
// Generic single write port, single read port RAM with registered read data.
module dmnf_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/depth_mask_neighbor_fill_unit.sv
// Top level: one 3x3 hole filling pass over a raster stream of mask bits and depths.
// Output: an item's result leaves with the item accepted width + 1 items later, then passes
//   the stage 1 registers (line store read) and the result queue before it shows on rsp_ch.
// Throughput: one item per cycle if the queue has room; set by the single line store ports.
// Reset: registers return to 640 x 480, counters and queue clear; line store is not cleared.
module depth_mask_neighbor_fill_unit
   import dmnf_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dmnf_req_if.sink   req_ch,
   dmnf_rsp_if.source rsp_ch,
   dmnf_csr_if.sink   csr_ch
);

   localparam int AW   = $clog2(MAX_WIDTH);
   localparam int WCAP = (MAX_WIDTH > (1 << FW_W) - 1) ? (1 << FW_W) - 1 : MAX_WIDTH;
   localparam logic [FW_W-1:0] WCAP_V = FW_W'(WCAP);

   // configuration
   logic [FW_W-1:0] frame_width_ff;
   logic [FH_W-1:0] frame_height_ff;
   logic            csr_wr;
   logic [FW_W-1:0] w_eff;
   logic [FH_W-1:0] h_eff;

   // input position
   logic [AW-1:0]    col_ff,  col_in;
   logic [ROW_W-1:0] row_ff,  row_in;

   // stage 0 decode
   logic               accept;
   logic [COL_X_W-1:0] c_ext, w_ext, rc;
   logic [ROW_X_W-1:0] r_ext, h_ext, b;
   logic               emit, wrap;
   row_ok_type         row_ok;
   col_ok_type         col_ok;
   pix_type            pix;

   // stage 1
   logic          s1_valid_ff;
   logic          s1_emit_ff;
   logic          s1_last_ff;
   pix_type       s1_pix_ff;
   logic [AW-1:0] s1_col_ff;
   row_ok_type    s1_row_ok_ff;
   col_ok_type    s1_col_ok_ff;
   logic          fwd_ff;
   pair_type      fwd_data_ff;
   pair_type      ram_rd, rd_pair, wr_pair;
   col_type       new_col;
   col_type       win0_ff, win1_ff;

   // decision
   pix_type self_pix, src;
   logic    found;
   rsp_type result;

   // result queue
   rsp_type                 fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   cnt_ff;
   logic                    push, pop;
   logic [FIFO_CNT_W:0]     pending;

   // effective frame size
   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = FW_W'(1);
      end else if (frame_width_ff > WCAP_V) begin
         w_eff = WCAP_V;
      end else begin
         w_eff = frame_width_ff;
      end
      h_eff = (frame_height_ff == '0) ? FH_W'(1) : frame_height_ff;
   end

   // handshakes
   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid && csr_ch.ready;
   assign pending      = (FIFO_CNT_W + 1)'(cnt_ff) + (FIFO_CNT_W + 1)'(s1_valid_ff && s1_emit_ff);
   assign req_ch.ready = pending < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
   assign accept       = req_ch.valid && req_ch.ready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_wr) begin
         unique case (csr_ch.index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_ch.data[FW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_ch.data[FH_W-1:0];
            default:          frame_width_ff  <= frame_width_ff;
         endcase
      end
   end

   // position decode: output pixel sits one row and one column behind the input
   always_comb begin
      c_ext = COL_X_W'(col_ff);
      w_ext = COL_X_W'(w_eff);
      r_ext = ROW_X_W'(row_ff);
      h_ext = ROW_X_W'(h_eff);
      emit  = (row_ff >= ROW_W'(2)) || ((row_ff == ROW_W'(1)) && (col_ff != '0));
      wrap  = (col_ff == '0) && (row_ff == ROW_W'(h_eff) + ROW_W'(1));
      // rightmost column and bottom row of the neighbourhood
      rc    = (col_ff == '0) ? w_ext : c_ext;
      b     = (col_ff == '0) ? r_ext - ROW_X_W'(1) : r_ext;
      col_ok.right  = (rc >= COL_X_W'(1)) && (rc + COL_X_W'(2) <= w_ext);
      col_ok.centre = (rc >= COL_X_W'(2)) && (rc + COL_X_W'(1) <= w_ext);
      col_ok.left   = (rc >= COL_X_W'(3)) && (rc <= w_ext);
      row_ok.bot    = (b >= ROW_X_W'(1)) && (b + ROW_X_W'(2) <= h_ext);
      row_ok.mid    = (b >= ROW_X_W'(2)) && (b + ROW_X_W'(1) <= h_ext);
      row_ok.top    = (b >= ROW_X_W'(3)) && (b <= h_ext);
      // flush items enter as invalid zero pixels
      pix.valid = req_ch.mask_in && !req_ch.flush;
      pix.depth = req_ch.flush ? '0 : req_ch.depth_in;
   end

   // input position counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_wr || (accept && wrap)) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (c_ext + COL_X_W'(1) >= w_ext) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line store: both rows above the input in one entry per column
   dmnf_ram #(
      .WIDTH($bits(pair_type)),
      .DEPTH(MAX_WIDTH)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (s1_valid_ff),
      .wr_addr(s1_col_ff),
      .wr_data(wr_pair),
      .rd_en  (accept),
      .rd_addr(col_ff),
      .rd_data(ram_rd)
   );

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff   <= emit;
         s1_last_ff   <= wrap;
         s1_pix_ff    <= pix;
         s1_col_ff    <= col_ff;
         s1_row_ok_ff <= row_ok;
         s1_col_ok_ff <= col_ok;
         // same column written back this edge: RAM read returns stale data
         fwd_ff       <= s1_valid_ff && (s1_col_ff == col_ff);
         fwd_data_ff  <= wr_pair;
      end
   end

   // read-modify-write of the line store entry
   always_comb begin
      rd_pair        = fwd_ff ? fwd_data_ff : ram_rd;
      new_col.top    = rd_pair.older;
      new_col.mid    = rd_pair.newer;
      new_col.bot    = s1_pix_ff;
      wr_pair.older  = rd_pair.newer;
      wr_pair.newer  = s1_pix_ff;
   end

   // window shift
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win0_ff <= new_col;
         win1_ff <= win0_ff;
      end
   end

   // fill decision: last valid interior neighbour in raster order wins
   always_comb begin
      self_pix = win0_ff.mid;
      src      = '0;
      found    = 1'b0;
      if (win1_ff.top.valid && s1_row_ok_ff.top && s1_col_ok_ff.left) begin
         src = win1_ff.top;  found = 1'b1;
      end
      if (win0_ff.top.valid && s1_row_ok_ff.top && s1_col_ok_ff.centre) begin
         src = win0_ff.top;  found = 1'b1;
      end
      if (new_col.top.valid && s1_row_ok_ff.top && s1_col_ok_ff.right) begin
         src = new_col.top;  found = 1'b1;
      end
      if (win1_ff.mid.valid && s1_row_ok_ff.mid && s1_col_ok_ff.left) begin
         src = win1_ff.mid;  found = 1'b1;
      end
      if (new_col.mid.valid && s1_row_ok_ff.mid && s1_col_ok_ff.right) begin
         src = new_col.mid;  found = 1'b1;
      end
      if (win1_ff.bot.valid && s1_row_ok_ff.bot && s1_col_ok_ff.left) begin
         src = win1_ff.bot;  found = 1'b1;
      end
      if (win0_ff.bot.valid && s1_row_ok_ff.bot && s1_col_ok_ff.centre) begin
         src = win0_ff.bot;  found = 1'b1;
      end
      if (new_col.bot.valid && s1_row_ok_ff.bot && s1_col_ok_ff.right) begin
         src = new_col.bot;  found = 1'b1;
      end
      if (!self_pix.valid && found) begin
         result.mask_out  = 1'b1;
         result.depth_out = src.depth;
      end else begin
         result.mask_out  = self_pix.valid;
         result.depth_out = self_pix.depth;
      end
      result.frame_end = s1_last_ff;
   end

   // result queue
   assign push = s1_valid_ff && s1_emit_ff;
   assign pop  = rsp_ch.valid && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + FIFO_PTR_W'(1);
         end
         cnt_ff <= cnt_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      end
   end

   assign rsp_ch.valid     = cnt_ff != '0;
   assign rsp_ch.mask_out  = fifo_ff[rd_ptr_ff].mask_out;
   assign rsp_ch.depth_out = fifo_ff[rd_ptr_ff].depth_out;
   assign rsp_ch.frame_end = fifo_ff[rd_ptr_ff].frame_end;

   // checks
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (cnt_ff == FIFO_CNT_W'(FIFO_DEPTH))))
      else $error("result queue overflow");

   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue count out of range");

   a_s1_from_accept : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(accept))
      else $error("stage 1 item without an accepted item");

   a_wrap_restart : assert property (@(posedge clock) disable iff (reset)
      (accept && wrap) |=> (col_ff == '0 && row_ff == '0))
      else $error("frame counters did not restart");

endmodule
